// File: rtl/gcrld_pkg.sv
// Shared types and constants of the grid column run-length decoder.
`default_nettype none

package gcrld_pkg;

  // Fixed widths of the cell command fields
  localparam int unsigned COORD_W = 8;   // widest x or z index (up to 256 columns)
  localparam int unsigned BASE_W  = 21;  // widest column base address
  localparam int unsigned CNT_W   = 6;   // cells per command, 1 to 32
  localparam int unsigned LAYER_W = 6;   // saturating layer counter

  // Command queue between the parser and the cell generator
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_PTR_W = 2;
  localparam int unsigned Q_CNT_W = 3;

  // Flags byte layout
  localparam logic [4:0] RUN_MASK   = 5'h1F;
  localparam logic [2:0] MODE_EMPTY = 3'b000;  // flags 0x00
  localparam logic [2:0] MODE_LIT   = 3'b010;  // flags 0x40
  localparam logic [2:0] MODE_REP   = 3'b100;  // flags 0x80

  localparam logic [CNT_W-1:0] MAX_RUN = 6'd32;
  localparam logic [LAYER_W-1:0] LAYER_SAT = 6'd63;
  localparam logic [4:0] LAYER_Y_SAT = 5'd31;

  // One run of cells to emit
  typedef struct packed {
    logic [7:0]         layout;
    logic [7:0]         brick;
    logic [CNT_W-1:0]   cnt;
    logic [LAYER_W-1:0] layer;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] z;
    logic [BASE_W-1:0]  base;
  } cmd_t;

endpackage

`default_nettype wire

// File: rtl/grid_column_run_length_decoder.sv
// Top level of the grid column run-length decoder.
//
// Input stream: one compressed byte per transaction on s_axis; tuser marks a
// restart at column zero, where that byte is the first column's group count.
// Output stream: one voxel cell per transaction on m_axis; tlast marks the
// last cell caused by one input byte, tuser flags a layer past the grid
// height (address reads zero, the write is to be dropped).
// The parser takes one byte per cycle whenever the four-entry command queue
// has room. Each byte that yields cells queues one command; the cell
// generator expands it at one cell per cycle while the receiver accepts,
// so a run of 1 to 32 cells holds the generator. Other bytes queue nothing.
// A stalled receiver holds the output register; the generator, then the
// queue and finally s_axis_tready back up behind it. Nothing is dropped.
// Reset clears the parser to expect a group count at column zero and
// empties the queue and the output register.
`default_nettype none

module grid_column_run_length_decoder #(
  parameter int unsigned COLUMNS_X = 64,
  parameter int unsigned COLUMNS_Z = 64,
  parameter int unsigned LAYERS    = 25
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  wire logic [0:0]  s_axis_tuser_i,   // [0] grid_start
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  output logic [55:0]      m_axis_tdata_o,   // [7:0] layout_code, [15:8] brick_code,
                                             // [21:16] col_x, [26:22] layer_y,
                                             // [32:27] row_z, [49:33] cell_address
  output logic [0:0]       m_axis_tuser_o,   // [0] overflow
  output logic             m_axis_tlast_o,   // last_of_run
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i
);

  logic            accept;
  logic            push, full, pop, head_valid;
  gcrld_pkg::cmd_t push_cmd, head_cmd;

  assign s_axis_tready_o = !full;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  gcrld_front #(
    .COLUMNS_X (COLUMNS_X),
    .COLUMNS_Z (COLUMNS_Z),
    .LAYERS    (LAYERS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .byte_i   (s_axis_tdata_i),
    .start_i  (s_axis_tuser_i[0]),
    .push_o   (push),
    .cmd_o    (push_cmd)
  );

  gcrld_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (head_valid),
    .head_o      (head_cmd)
  );

  gcrld_back #(
    .LAYERS (LAYERS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_valid_i    (head_valid),
    .head_i          (head_cmd),
    .pop_o           (pop),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i)
  );

endmodule

`default_nettype wire

// File: rtl/gcrld_front.sv
// Byte parser: walks columns and groups and turns them into cell commands.
`default_nettype none

module gcrld_front #(
  parameter int unsigned COLUMNS_X = 64,
  parameter int unsigned COLUMNS_Z = 64,
  parameter int unsigned LAYERS    = 25
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              accept_i,
  input  wire logic [7:0]        byte_i,
  input  wire logic              start_i,
  output logic                   push_o,
  output gcrld_pkg::cmd_t        cmd_o
);

  localparam int unsigned XW = (COLUMNS_X > 1) ? $clog2(COLUMNS_X) : 1;
  localparam int unsigned ZW = (COLUMNS_Z > 1) ? $clog2(COLUMNS_Z) : 1;
  localparam int unsigned BW = gcrld_pkg::BASE_W;
  localparam int unsigned LW = gcrld_pkg::LAYER_W;
  localparam int unsigned CW = gcrld_pkg::CNT_W;

  typedef enum logic [5:0] {
    PH_COUNT      = 6'b000001,
    PH_FLAGS      = 6'b000010,
    PH_LIT_LAYOUT = 6'b000100,
    PH_LIT_BRICK  = 6'b001000,
    PH_REP_LAYOUT = 6'b010000,
    PH_REP_BRICK  = 6'b100000
  } phase_e;

  phase_e        phase_q, phase_d, phase_e_c;
  logic [7:0]    groups_q, groups_d, groups_c;
  logic [CW-1:0] run_q, run_d, run_c;
  logic [7:0]    held_q, held_d, held_c;
  logic [LW-1:0] layer_q, layer_d, layer_c;
  logic [XW-1:0] x_q, x_d, x_c, x_nx;
  logic [ZW-1:0] z_q, z_d, z_c, z_nx;
  logic [BW-1:0] zbase_q, zbase_d, zbase_c, zbase_nx;
  logic [BW-1:0] base_q, base_d, base_c, base_nx;

  logic [7:0]    groups_dec;
  logic [CW-1:0] run_len, run_dec, cmd_cnt;
  logic [LW:0]   layer_sum;
  logic [LW-1:0] layer_adv;

  // Restart at column zero when the transaction carries the start flag
  always_comb begin
    phase_e_c = start_i ? PH_COUNT : phase_q;
    groups_c  = start_i ? '0 : groups_q;
    run_c     = start_i ? '0 : run_q;
    held_c    = start_i ? '0 : held_q;
    layer_c   = start_i ? '0 : layer_q;
    x_c       = start_i ? '0 : x_q;
    z_c       = start_i ? '0 : z_q;
    zbase_c   = start_i ? '0 : zbase_q;
    base_c    = start_i ? '0 : base_q;
  end

  // Advance to the next column, keeping the base address incrementally
  always_comb begin
    x_nx     = x_c + XW'(1);
    z_nx     = z_c;
    zbase_nx = zbase_c;
    base_nx  = base_c + BW'(COLUMNS_Z * LAYERS);
    if (x_c == XW'(COLUMNS_X - 1)) begin
      x_nx = '0;
      if (z_c == ZW'(COLUMNS_Z - 1)) begin
        z_nx     = '0;
        zbase_nx = '0;
        base_nx  = '0;
      end else begin
        z_nx     = z_c + ZW'(1);
        zbase_nx = zbase_c + BW'(LAYERS);
        base_nx  = zbase_c + BW'(LAYERS);
      end
    end
  end

  assign groups_dec = groups_c - 8'd1;
  assign run_len    = {1'b0, byte_i[4:0] & gcrld_pkg::RUN_MASK} + CW'(1);
  assign run_dec    = (run_c != '0) ? run_c - CW'(1) : '0;

  // Pick the cell count of the command, if any
  always_comb begin
    cmd_cnt = '0;
    case (phase_e_c)
      PH_FLAGS: begin
        if (byte_i[7:5] == gcrld_pkg::MODE_EMPTY) cmd_cnt = run_len;
      end
      PH_LIT_BRICK: cmd_cnt = CW'(1);
      PH_REP_BRICK: cmd_cnt = (run_c > gcrld_pkg::MAX_RUN) ? gcrld_pkg::MAX_RUN : run_c;
      default: cmd_cnt = '0;
    endcase
  end

  // Saturate the layer counter after the cells of this command
  assign layer_sum = {1'b0, layer_c} + (LW + 1)'(cmd_cnt);
  assign layer_adv = layer_sum[LW] ? gcrld_pkg::LAYER_SAT : layer_sum[LW-1:0];

  // Step the parser
  always_comb begin
    logic end_group;
    logic next_col;
    end_group = 1'b0;
    next_col  = 1'b0;
    phase_d   = phase_e_c;
    groups_d  = groups_c;
    run_d     = run_c;
    held_d    = held_c;
    layer_d   = layer_adv;
    x_d       = x_c;
    z_d       = z_c;
    zbase_d   = zbase_c;
    base_d    = base_c;
    case (phase_e_c)
      PH_COUNT: begin
        groups_d = byte_i;
        layer_d  = '0;
        if (byte_i == 8'd0) next_col = 1'b1;
        else phase_d = PH_FLAGS;
      end
      PH_FLAGS: begin
        case (byte_i[7:5])
          gcrld_pkg::MODE_LIT: begin
            run_d   = run_len;
            phase_d = PH_LIT_LAYOUT;
          end
          gcrld_pkg::MODE_REP: begin
            run_d   = run_len;
            phase_d = PH_REP_LAYOUT;
          end
          default: end_group = 1'b1;
        endcase
      end
      PH_LIT_LAYOUT: begin
        held_d  = byte_i;
        phase_d = PH_LIT_BRICK;
      end
      PH_LIT_BRICK: begin
        if (run_dec == '0) begin
          end_group = 1'b1;
        end else begin
          run_d   = run_dec;
          phase_d = PH_LIT_LAYOUT;
        end
      end
      PH_REP_LAYOUT: begin
        held_d  = byte_i;
        phase_d = PH_REP_BRICK;
      end
      PH_REP_BRICK: end_group = 1'b1;
      default: phase_d = PH_COUNT;
    endcase
    if (end_group) begin
      groups_d = groups_dec;
      run_d    = '0;
      if (groups_dec == 8'd0) next_col = 1'b1;
      else phase_d = PH_FLAGS;
    end
    if (next_col) begin
      layer_d = '0;
      phase_d = PH_COUNT;
      x_d     = x_nx;
      z_d     = z_nx;
      zbase_d = zbase_nx;
      base_d  = base_nx;
    end
  end

  // Build the command for the cell generator
  always_comb begin
    push_o       = accept_i && (cmd_cnt != '0);
    cmd_o.layout = (phase_e_c == PH_FLAGS) ? 8'd0 : held_c;
    cmd_o.brick  = (phase_e_c == PH_FLAGS) ? 8'd0 : byte_i;
    cmd_o.cnt    = cmd_cnt;
    cmd_o.layer  = layer_c;
    cmd_o.x      = gcrld_pkg::COORD_W'(x_c);
    cmd_o.z      = gcrld_pkg::COORD_W'(z_c);
    cmd_o.base   = base_c;
  end

  // Hold parser state between transactions
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_COUNT;
      groups_q <= '0;
      run_q    <= '0;
      held_q   <= '0;
      layer_q  <= '0;
      x_q      <= '0;
      z_q      <= '0;
      zbase_q  <= '0;
      base_q   <= '0;
    end else if (accept_i) begin
      phase_q  <= phase_d;
      groups_q <= groups_d;
      run_q    <= run_d;
      held_q   <= held_d;
      layer_q  <= layer_d;
      x_q      <= x_d;
      z_q      <= z_d;
      zbase_q  <= zbase_d;
      base_q   <= base_d;
    end
  end

  // A pushed command always carries one to thirty-two cells
  a_cmd_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> (cmd_o.cnt != '0) && (cmd_o.cnt <= gcrld_pkg::MAX_RUN))
    else $error("cell command with bad count");

endmodule

`default_nettype wire

// File: rtl/gcrld_queue.sv
// Short command queue between the parser and the cell generator.
`default_nettype none

module gcrld_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire gcrld_pkg::cmd_t push_data_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output logic                 valid_o,
  output gcrld_pkg::cmd_t      head_o
);

  gcrld_pkg::cmd_t                 mem_q [gcrld_pkg::Q_DEPTH];
  logic [gcrld_pkg::Q_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [gcrld_pkg::Q_CNT_W-1:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == gcrld_pkg::Q_CNT_W'(gcrld_pkg::Q_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  // Write the entry at the tail
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Track fill level and pointers
  always_comb begin
    cnt_d = cnt_q;
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + gcrld_pkg::Q_CNT_W'(1);
      2'b01:   cnt_d = cnt_q - gcrld_pkg::Q_CNT_W'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + gcrld_pkg::Q_PTR_W'(1);
      if (pop_i)  rd_ptr_q <= rd_ptr_q + gcrld_pkg::Q_PTR_W'(1);
      cnt_q <= cnt_d;
    end
  end

  // Never write into a full queue nor read from an empty one
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i |-> !full_o) and (pop_i |-> valid_o))
    else $error("command queue overrun or underrun");

endmodule

`default_nettype wire

// File: rtl/gcrld_back.sv
// Cell generator: expands queued commands into one output cell per cycle while the receiver is ready.
`default_nettype none

module gcrld_back #(
  parameter int unsigned LAYERS = 25
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            head_valid_i,
  input  wire gcrld_pkg::cmd_t head_i,
  output logic                 pop_o,
  output logic [55:0]          m_axis_tdata_o,
  output logic [0:0]           m_axis_tuser_o,
  output logic                 m_axis_tlast_o,
  output logic                 m_axis_tvalid_o,
  input  wire logic            m_axis_tready_i
);

  localparam int unsigned LW = gcrld_pkg::LAYER_W;

  logic [4:0]    idx_q, idx_d;
  logic          emit, last;
  logic [LW:0]   layer_sum;
  logic [LW-1:0] layer;
  logic          ovf;
  logic [4:0]    layer_y;
  logic [gcrld_pkg::BASE_W-1:0] addr;

  logic          valid_q;
  logic [7:0]    layout_q, brick_q;
  logic [5:0]    x_q, z_q;
  logic [4:0]    y_q;
  logic [16:0]   addr_q;
  logic          ovf_q, last_q;

  // Emit a cell whenever a command is queued and the output register is free or draining
  assign emit = head_valid_i && (!valid_q || m_axis_tready_i);
  assign last = ((LW)'(idx_q) + (LW)'(1)) == head_i.cnt;
  assign pop_o = emit && last;
  assign idx_d = last ? 5'd0 : idx_q + 5'd1;

  // Work out the cell position inside the column
  assign layer_sum = {1'b0, head_i.layer} + (LW + 1)'(idx_q);
  assign layer     = layer_sum[LW] ? gcrld_pkg::LAYER_SAT : layer_sum[LW-1:0];
  assign ovf       = (layer >= LW'(LAYERS));
  assign layer_y   = layer[LW-1] ? gcrld_pkg::LAYER_Y_SAT : layer[4:0];
  assign addr      = ovf ? '0 : head_i.base + gcrld_pkg::BASE_W'(layer);

  // Advance the cell offset within the current command
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (emit) idx_q <= idx_d;
      valid_q <= emit || (valid_q && !m_axis_tready_i);
    end
  end

  // Load the output register
  always_ff @(posedge clk_i) begin
    if (emit) begin
      layout_q <= head_i.layout;
      brick_q  <= head_i.brick;
      x_q      <= head_i.x[5:0];
      z_q      <= head_i.z[5:0];
      y_q      <= layer_y;
      addr_q   <= addr[16:0];
      ovf_q    <= ovf;
      last_q   <= last;
    end
  end

  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tdata_o  = {6'd0, addr_q, z_q, y_q, x_q, brick_q, layout_q};
  assign m_axis_tuser_o  = ovf_q;
  assign m_axis_tlast_o  = last_q;

  // The offset stays inside the command it walks
  a_idx_in_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_valid_i |-> ((LW)'(idx_q) < head_i.cnt))
    else $error("cell offset beyond command length");

  // An emitted cell is presented in the next cycle
  a_emit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> m_axis_tvalid_o)
    else $error("emitted cell not presented");

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// Self-checking testbench of the grid column run-length decoder.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned COLS_X      = 64;
  localparam int unsigned COLS_Z      = 64;
  localparam int unsigned GRID_LAYERS = 25;
  localparam int unsigned RANDOM_BYTES = 380;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned SETTLE_CYCLES = 40;

  // Modes that consume the group and emit nothing
  localparam logic [2:0] MODE_RSV_20 = 3'b001;
  localparam logic [2:0] MODE_RSV_60 = 3'b011;
  localparam logic [2:0] MODE_RSV_A0 = 3'b101;
  localparam logic [2:0] MODE_RSV_C0 = 3'b110;
  localparam logic [2:0] MODE_RSV_E0 = 3'b111;

  typedef enum logic [2:0] {
    ST_GROUP_COUNT,
    ST_FLAGS,
    ST_LIT_LAYOUT,
    ST_LIT_BRICK,
    ST_REP_LAYOUT,
    ST_REP_BRICK
  } parse_state_e;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
    logic       drain;   // hold this byte until every predicted cell has arrived
  } stream_byte_t;

  typedef struct packed {
    logic [7:0]  layout;
    logic [7:0]  brick;
    logic [5:0]  x;
    logic [4:0]  y;
    logic [5:0]  z;
    logic [16:0] addr;
    logic        ovf;
    logic        last;
  } cell_t;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  logic [7:0]  s_tdata  = '0;
  logic [0:0]  s_tuser  = '0;
  logic        s_tvalid = 1'b0;
  logic        m_tready = 1'b0;
  logic        rx_hold  = 1'b0;
  logic        tx_quiet = 1'b0;
  logic        rx_quiet = 1'b0;

  wire         s_axis_tready_o;
  wire [55:0]  m_axis_tdata_o;
  wire [0:0]   m_axis_tuser_o;
  wire         m_axis_tlast_o;
  wire         m_axis_tvalid_o;

  stream_byte_t byte_queue [$];
  cell_t        cells_due [$];
  stream_byte_t tx_item;

  int unsigned tx_gap = 0;
  int unsigned rx_gap = 0;
  int unsigned bytes_taken = 0;
  int unsigned total_bytes = 0;
  int unsigned hold_mark = 0;
  int unsigned cells_checked = 0;
  int unsigned mismatches = 0;

  // Predictor state
  parse_state_e parse_state = ST_GROUP_COUNT;
  logic [7:0]   groups_left = '0;
  logic [5:0]   run_left    = '0;
  logic [7:0]   held_layout = '0;
  logic [5:0]   layer_count = '0;
  int unsigned  column_index = 0;

  grid_column_run_length_decoder #(
    .COLUMNS_X(COLS_X),
    .COLUMNS_Z(COLS_Z),
    .LAYERS   (GRID_LAYERS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_axis_tready_o),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_tready)
  );

  // Clock and reset
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Mostly short idle gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input int unsigned got, input int unsigned want);
    if (got != want)
      report_mismatch($sformatf("cell %0d %s: got %0d, expected %0d",
                                cells_checked, name, got, want));
  endtask

  // Predict one cell at the current column and layer
  task automatic push_cell(input logic [7:0] layout, input logic [7:0] brick);
    cell_t c;
    int unsigned x, z, y;
    x = column_index % COLS_X;
    z = column_index / COLS_X;
    y = layer_count;
    c.layout = layout;
    c.brick  = brick;
    c.x      = x[5:0];
    c.z      = z[5:0];
    c.y      = (y > gcrld_pkg::LAYER_Y_SAT) ? gcrld_pkg::LAYER_Y_SAT : y[4:0];
    c.ovf    = (y >= GRID_LAYERS);
    c.addr   = c.ovf ? 17'd0 : 17'(x * COLS_Z * GRID_LAYERS + z * GRID_LAYERS + y);
    c.last   = 1'b0;
    cells_due.push_back(c);
    if (layer_count < gcrld_pkg::LAYER_SAT) layer_count++;
  endtask

  task automatic advance_column();
    layer_count = '0;
    column_index++;
    if (column_index >= COLS_X * COLS_Z) column_index = 0;
    parse_state = ST_GROUP_COUNT;
  endtask

  task automatic close_group();
    groups_left = groups_left - 8'd1;
    run_left = '0;
    if (groups_left == 8'd0) advance_column();
    else parse_state = ST_FLAGS;
  endtask

  // Advance the predictor by one accepted byte and queue the cells it causes
  task automatic decode_byte(input logic [7:0] b, input logic restart);
    int unsigned n_before, i;
    logic [5:0] len;
    logic [2:0] mode;
    cell_t tail;
    n_before = cells_due.size();
    if (restart) begin
      parse_state  = ST_GROUP_COUNT;
      groups_left  = '0;
      run_left     = '0;
      held_layout  = '0;
      layer_count  = '0;
      column_index = 0;
    end
    len  = {1'b0, b[4:0] & gcrld_pkg::RUN_MASK} + 6'd1;
    mode = b[7:5];
    case (parse_state)
      ST_GROUP_COUNT: begin
        groups_left = b;
        layer_count = '0;
        if (b == 8'd0) advance_column();
        else parse_state = ST_FLAGS;
      end
      ST_FLAGS: begin
        if (mode == gcrld_pkg::MODE_EMPTY) begin
          for (i = 0; i < len; i++) push_cell(8'd0, 8'd0);
          close_group();
        end else if (mode == gcrld_pkg::MODE_LIT) begin
          run_left = len;
          parse_state = ST_LIT_LAYOUT;
        end else if (mode == gcrld_pkg::MODE_REP) begin
          run_left = len;
          parse_state = ST_REP_LAYOUT;
        end else begin
          close_group();
        end
      end
      ST_LIT_LAYOUT: begin
        held_layout = b;
        parse_state = ST_LIT_BRICK;
      end
      ST_LIT_BRICK: begin
        push_cell(held_layout, b);
        if (run_left != 0) run_left--;
        if (run_left == 0) close_group();
        else parse_state = ST_LIT_LAYOUT;
      end
      ST_REP_LAYOUT: begin
        held_layout = b;
        parse_state = ST_REP_BRICK;
      end
      ST_REP_BRICK: begin
        for (i = 0; i < run_left && i < gcrld_pkg::MAX_RUN; i++) push_cell(held_layout, b);
        close_group();
      end
      default: parse_state = ST_GROUP_COUNT;
    endcase
    // Mark the final cell of this byte
    if (cells_due.size() > n_before) begin
      tail = cells_due.pop_back();
      tail.last = 1'b1;
      cells_due.push_back(tail);
    end
  endtask

  // Compare one output transaction with the oldest prediction
  task automatic check_cell();
    cell_t want;
    if (cells_due.size() == 0) begin
      report_mismatch($sformatf("cell with no prediction, tdata %h", m_axis_tdata_o));
    end else begin
      want = cells_due.pop_front();
      check_field("layout_code",  32'(m_axis_tdata_o[7:0]),   32'(want.layout));
      check_field("brick_code",   32'(m_axis_tdata_o[15:8]),  32'(want.brick));
      check_field("col_x",        32'(m_axis_tdata_o[21:16]), 32'(want.x));
      check_field("layer_y",      32'(m_axis_tdata_o[26:22]), 32'(want.y));
      check_field("row_z",        32'(m_axis_tdata_o[32:27]), 32'(want.z));
      check_field("cell_address", 32'(m_axis_tdata_o[49:33]), 32'(want.addr));
      check_field("overflow",     32'(m_axis_tuser_o[0]),     32'(want.ovf));
      check_field("last_of_run",  32'(m_axis_tlast_o),        32'(want.last));
    end
    cells_checked++;
  endtask

  // Driver: predict on each accepted byte, then offer the next one
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      s_tuser  <= '0;
      tx_gap   <= 0;
    end else begin
      if (s_tvalid && s_axis_tready_o) begin
        decode_byte(s_tdata, s_tuser[0]);
        bytes_taken <= bytes_taken + 1;
      end
      if (!s_tvalid || s_axis_tready_o) begin
        if (tx_gap != 0) begin
          tx_gap   <= tx_gap - 1;
          s_tvalid <= 1'b0;
        end else if (byte_queue.size() != 0 &&
                     !(byte_queue[0].drain && cells_due.size() != 0)) begin
          tx_item  = byte_queue.pop_front();
          s_tdata  <= tx_item.data;
          s_tuser  <= tx_item.start;
          s_tvalid <= 1'b1;
          tx_gap   <= tx_quiet ? 0 : pick_gap();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
      if ($urandom_range(199) == 0) tx_quiet <= !tx_quiet;
    end
  end

  // Monitor: check accepted cells, stall the output at random
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tready <= 1'b0;
      rx_gap   <= 0;
    end else begin
      if (m_axis_tvalid_o && m_tready) check_cell();
      if (rx_hold || rx_gap != 0) begin
        m_tready <= 1'b0;
        if (rx_gap != 0) rx_gap <= rx_gap - 1;
      end else begin
        m_tready <= 1'b1;
        if (!rx_quiet && $urandom_range(3) == 0) rx_gap <= pick_gap();
      end
      if ($urandom_range(199) == 0) rx_quiet <= !rx_quiet;
    end
  end

  // Long receiver hold-off while the sender keeps offering bytes
  initial begin
    while (hold_mark == 0 || bytes_taken < hold_mark) @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  task automatic add_byte(input logic [7:0] data, input logic start, input logic drain);
    stream_byte_t b;
    b.data  = data;
    b.start = start;
    b.drain = drain;
    byte_queue.push_back(b);
  endtask

  // One group with random mode, length and content
  task automatic add_group();
    int unsigned r, len, i;
    logic [2:0] mode;
    r = $urandom_range(99);
    if (r < 25) mode = gcrld_pkg::MODE_EMPTY;
    else if (r < 55) mode = gcrld_pkg::MODE_LIT;
    else if (r < 85) mode = gcrld_pkg::MODE_REP;
    else begin
      case ($urandom_range(4))
        0: mode = MODE_RSV_20;
        1: mode = MODE_RSV_60;
        2: mode = MODE_RSV_A0;
        3: mode = MODE_RSV_C0;
        default: mode = MODE_RSV_E0;
      endcase
    end
    if (mode == gcrld_pkg::MODE_LIT)
      len = ($urandom_range(19) == 0) ? $urandom_range(32, 1) : $urandom_range(6, 1);
    else
      len = ($urandom_range(4) == 0) ? $urandom_range(32, 1) : $urandom_range(8, 1);
    add_byte({mode, 5'(len - 1)}, 1'b0, 1'b0);
    if (mode == gcrld_pkg::MODE_LIT) begin
      for (i = 0; i < len; i++) begin
        add_byte(8'($urandom_range(255)), 1'b0, 1'b0);
        add_byte(8'($urandom_range(255)), 1'b0, 1'b0);
      end
    end else if (mode == gcrld_pkg::MODE_REP) begin
      add_byte(8'($urandom_range(255)), 1'b0, 1'b0);
      add_byte(8'($urandom_range(255)), 1'b0, 1'b0);
    end
  endtask

  // One column; a few are cut short to break the sequence
  task automatic add_column(input logic restart);
    int unsigned r, groups, g;
    r = $urandom_range(99);
    if (r < 10) groups = 0;
    else if (r < 90) groups = $urandom_range(3, 1);
    else groups = $urandom_range(8, 4);
    add_byte(groups[7:0], restart, ($urandom_range(29) == 0));
    for (g = 0; g < groups; g++) begin
      if ($urandom_range(39) == 0) break;
      add_group();
    end
  endtask

  // Stimulus and end of run
  initial begin
    int unsigned i, rand_base, sel;

    // Directed: long runs into layer overflow, empty column, unused modes, short runs
    add_byte(8'd3, 1'b1, 1'b0);
    add_byte({gcrld_pkg::MODE_EMPTY, 5'h1F}, 1'b0, 1'b0);
    add_byte({gcrld_pkg::MODE_REP, 5'h1F}, 1'b0, 1'b0);
    add_byte(8'hFF, 1'b0, 1'b0);
    add_byte(8'hFF, 1'b0, 1'b0);
    add_byte({gcrld_pkg::MODE_LIT, 5'h00}, 1'b0, 1'b0);
    add_byte(8'h00, 1'b0, 1'b0);
    add_byte(8'hAA, 1'b0, 1'b0);
    add_byte(8'd0, 1'b0, 1'b0);
    add_byte(8'd5, 1'b0, 1'b0);
    add_byte({MODE_RSV_20, 5'h00}, 1'b0, 1'b0);
    add_byte({MODE_RSV_60, 5'h1F}, 1'b0, 1'b0);
    add_byte({MODE_RSV_A0, 5'h03}, 1'b0, 1'b0);
    add_byte({MODE_RSV_C0, 5'h00}, 1'b0, 1'b0);
    add_byte({MODE_RSV_E0, 5'h1F}, 1'b0, 1'b0);
    add_byte(8'd2, 1'b0, 1'b0);
    add_byte({gcrld_pkg::MODE_LIT, 5'h01}, 1'b0, 1'b0);
    add_byte(8'h01, 1'b0, 1'b0);
    add_byte(8'h02, 1'b0, 1'b0);
    add_byte(8'h55, 1'b0, 1'b0);
    add_byte(8'hAA, 1'b0, 1'b0);
    add_byte({gcrld_pkg::MODE_REP, 5'h00}, 1'b0, 1'b0);
    add_byte(8'h00, 1'b0, 1'b0);
    add_byte(8'h01, 1'b0, 1'b0);

    // Walk empty columns to the end of the first row, then step into the next row
    add_byte(8'd0, 1'b1, 1'b1);
    for (i = 1; i < COLS_X - 1; i++) add_byte(8'd0, 1'b0, 1'b0);
    add_byte(8'd1, 1'b0, 1'b0);
    add_byte({gcrld_pkg::MODE_EMPTY, 5'h01}, 1'b0, 1'b0);
    add_byte(8'd1, 1'b0, 1'b0);
    add_byte({gcrld_pkg::MODE_EMPTY, 5'h00}, 1'b0, 1'b0);

    // Random columns with some noise and mid-stream restarts
    rand_base = byte_queue.size();
    hold_mark = rand_base + 60;
    add_byte(8'd1, 1'b1, 1'b1);
    add_byte({gcrld_pkg::MODE_REP, 5'h1F}, 1'b0, 1'b0);
    add_byte(8'($urandom_range(255)), 1'b0, 1'b0);
    add_byte(8'($urandom_range(255)), 1'b0, 1'b0);
    while (byte_queue.size() - rand_base < RANDOM_BYTES) begin
      sel = $urandom_range(99);
      if (sel < 8) add_byte(8'($urandom_range(255)), ($urandom_range(9) == 0), 1'b0);
      else add_column(sel < 16);
    end
    total_bytes = byte_queue.size();

    while (bytes_taken < total_bytes) @(posedge clk_i);
    while (cells_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && cells_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Run guard
  initial begin
    #40_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

`default_nettype wire

// File: filelist.f
rtl/gcrld_pkg.sv
rtl/gcrld_front.sv
rtl/gcrld_queue.sv
rtl/gcrld_back.sv
rtl/grid_column_run_length_decoder.sv
tb/tb_top.sv
